>>> design/quoted_string_unescape_macros.svh
// Assertion macros used by the checker file of the quoted string unescaper.
// Depends on nothing; the including module supplies clock and reset names.
`ifndef QUOTED_STRING_UNESCAPE_MACROS_SVH
`define QUOTED_STRING_UNESCAPE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define QSU_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");

// Next-cycle implication, disabled while reset is high.
`define QSU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

>>> design/qsu_pkg.sv
// Package of the quoted string unescaper: word types, phase codes, characters.
// Depends on nothing; every design module imports it.
`default_nettype none

package qsu_pkg;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       is_final;
   } req_type;

   typedef struct packed {
      logic       char_valid;
      logic [7:0] out_char;
      logic       text_end;
      logic       text_ok;
   } rsp_type;

   typedef enum logic [1:0] {
      PH_OPEN = 2'd0,
      PH_BODY = 2'd1,
      PH_ESC  = 2'd2,
      PH_HEX  = 2'd3
   } phase_type;

   typedef struct packed {
      logic       known;
      logic [7:0] value;
   } esc_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_type;

   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_BSLASH = 8'h5c;
   localparam logic [7:0] CHAR_LOW_B  = 8'h62;
   localparam logic [7:0] CHAR_LOW_F  = 8'h66;
   localparam logic [7:0] CHAR_LOW_N  = 8'h6e;
   localparam logic [7:0] CHAR_LOW_R  = 8'h72;
   localparam logic [7:0] CHAR_LOW_T  = 8'h74;
   localparam logic [7:0] CHAR_LOW_U  = 8'h75;
   localparam logic [7:0] CTRL_LIMIT  = 8'h20;
   localparam logic [7:0] CODE_BS     = 8'h08;
   localparam logic [7:0] CODE_FF     = 8'h0c;
   localparam logic [7:0] CODE_LF     = 8'h0a;
   localparam logic [7:0] CODE_CR     = 8'h0d;
   localparam logic [7:0] CODE_TAB    = 8'h09;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_UP_A   = 8'h41;
   localparam logic [7:0] CHAR_UP_F   = 8'h46;
   localparam logic [7:0] CHAR_LOW_A  = 8'h61;
   localparam logic [1:0] HEX_ZEROS   = 2'd2;
   localparam logic [1:0] HEX_LAST    = 2'd3;

   // Maps the byte after a backslash to the byte it stands for.
   function automatic esc_type escape_map(input logic [7:0] c);
      esc_type r;
      r.known = 1'b1;
      r.value = c;
      unique case (c)
         CHAR_QUOTE, CHAR_BSLASH: r.value = c;
         CHAR_LOW_B:              r.value = CODE_BS;
         CHAR_LOW_F:              r.value = CODE_FF;
         CHAR_LOW_N:              r.value = CODE_LF;
         CHAR_LOW_R:              r.value = CODE_CR;
         CHAR_LOW_T:              r.value = CODE_TAB;
         default: begin
            r.known = 1'b0;
            r.value = 8'h00;
         end
      endcase
      return r;
   endfunction

   // Value of one hex digit in either case.
   function automatic hex_type hex_digit(input logic [7:0] c);
      hex_type     r;
      logic [7:0]  d;
      d = 8'h00;
      r.valid = 1'b1;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         d = c - CHAR_ZERO;
      end else if (c >= CHAR_LOW_A && c <= CHAR_LOW_F) begin
         d = c - CHAR_LOW_A + 8'd10;
      end else if (c >= CHAR_UP_A && c <= CHAR_UP_F) begin
         d = c - CHAR_UP_A + 8'd10;
      end else begin
         r.valid = 1'b0;
      end
      r.value = d[3:0];
      return r;
   endfunction

endpackage

`default_nettype wire

>>> design/quoted_string_unescape.sv
// Top level of the quoted string unescaper: input register, decoder, result register.
// Depends on qsu_pkg, qsu_in_reg, qsu_decode and qsu_rsp_reg.
//
//   Channel   Ports              Word         Direction
//   request   req_valid/ready    req_type     in: one raw byte and its final flag
//   response  rsp_valid/ready    rsp_type     out: decoded byte and end-of-text status
//
// Each accepted request word yields exactly one response word.
// The block takes one word per cycle while the response side is not stalled; each word
// passes through the input register and the result register around the decoder.
// Reset is synchronous and active high; it returns the parser to the state that
// expects an opening quote.
// A stalled response holds its word; the input register keeps taking words as
// long as the result register has room.
`default_nettype none

module quoted_string_unescape (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  qsu_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output qsu_pkg::rsp_type rsp_data
);
   import qsu_pkg::*;

   // The decoder runs between the two registers; its state only advances when
   // the word in the input register moves into the result register.
   logic    take;
   logic    advance;
   req_type item;
   rsp_type result;

   qsu_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .take      (take),
      .advance   (advance),
      .item      (item)
   );

   qsu_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item),
      .result  (result)
   );

   qsu_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .result    (result),
      .space     (take),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

>>> design/qsu_in_reg.sv
// Input register of the unescaper: holds one request word for the decoder.
// Depends on qsu_pkg.
`default_nettype none

module qsu_in_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  qsu_pkg::req_type req_data,
   input  logic             take,
   output logic             advance,
   output qsu_pkg::req_type item
);
   import qsu_pkg::*;

   logic    valid_ff, valid_in;
   req_type item_ff;

   // The held word moves on whenever the result side has room.
   assign advance   = valid_ff && take;
   assign req_ready = !valid_ff || take;
   assign valid_in  = (req_valid && req_ready) || (valid_ff && !take);
   assign item      = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_data;
      end
   end

endmodule

`default_nettype wire

>>> design/qsu_decode.sv
// Decoder of the unescaper: parse phase, hex run state and failure flag.
// Depends on qsu_pkg.
`default_nettype none

module qsu_decode (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  qsu_pkg::req_type item,
   output qsu_pkg::rsp_type result
);
   import qsu_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [1:0] hex_cnt_ff, hex_cnt_in;
   logic [3:0] hex_acc_ff, hex_acc_in;
   logic       failed_ff, failed_in;

   logic [7:0] c;
   logic       fin;
   esc_type    esc;
   hex_type    hex;
   logic       emit;
   logic [7:0] ch;
   logic       ok;

   assign c   = item.in_byte;
   assign fin = item.is_final;
   assign esc = escape_map(c);
   assign hex = hex_digit(c);

   // Next state.
   always_comb begin
      phase_in   = phase_ff;
      hex_cnt_in = hex_cnt_ff;
      hex_acc_in = hex_acc_ff;
      failed_in  = failed_ff;
      if (!failed_ff) begin
         unique case (phase_ff)
            PH_OPEN: begin
               if (c != CHAR_QUOTE || fin) failed_in = 1'b1;
               else phase_in = PH_BODY;
            end
            PH_BODY: begin
               if (fin) begin
                  if (c != CHAR_QUOTE) failed_in = 1'b1;
               end else if (c == CHAR_QUOTE || c < CTRL_LIMIT) begin
                  failed_in = 1'b1;
               end else if (c == CHAR_BSLASH) begin
                  phase_in = PH_ESC;
               end
            end
            PH_ESC: begin
               if (fin) begin
                  failed_in = 1'b1;
               end else if (c == CHAR_LOW_U) begin
                  phase_in   = PH_HEX;
                  hex_cnt_in = 2'd0;
                  hex_acc_in = 4'd0;
               end else if (esc.known) begin
                  phase_in = PH_BODY;
               end else begin
                  failed_in = 1'b1;
               end
            end
            PH_HEX: begin
               if (fin || !hex.valid) begin
                  failed_in = 1'b1;
               end else if (hex_cnt_ff < HEX_ZEROS) begin
                  if (hex.value != 4'd0) failed_in = 1'b1;
                  else hex_cnt_in = hex_cnt_ff + 2'd1;
               end else if (hex_cnt_ff == HEX_ZEROS) begin
                  hex_acc_in = hex.value;
                  hex_cnt_in = HEX_LAST;
               end else begin
                  phase_in   = PH_BODY;
                  hex_cnt_in = 2'd0;
                  hex_acc_in = 4'd0;
               end
            end
            default: failed_in = 1'b1;
         endcase
      end
      // The final byte always returns the parser to its idle state.
      if (fin) begin
         phase_in   = PH_OPEN;
         hex_cnt_in = 2'd0;
         hex_acc_in = 4'd0;
         failed_in  = 1'b0;
      end
   end

   // Outputs.
   always_comb begin
      emit = 1'b0;
      ch   = 8'h00;
      ok   = 1'b0;
      if (!failed_ff) begin
         unique case (phase_ff)
            PH_OPEN: ;
            PH_BODY: begin
               if (fin) begin
                  ok = (c == CHAR_QUOTE);
               end else if (c != CHAR_QUOTE && c >= CTRL_LIMIT && c != CHAR_BSLASH) begin
                  emit = 1'b1;
                  ch   = c;
               end
            end
            PH_ESC: begin
               if (!fin && esc.known) begin
                  emit = 1'b1;
                  ch   = esc.value;
               end
            end
            PH_HEX: begin
               if (!fin && hex.valid && hex_cnt_ff == HEX_LAST) begin
                  emit = 1'b1;
                  ch   = {hex_acc_ff, hex.value};
               end
            end
            default: emit = 1'b0;
         endcase
      end
   end

   assign result.char_valid = emit;
   assign result.out_char   = ch;
   assign result.text_end   = fin;
   assign result.text_ok    = fin && ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_OPEN;
         hex_cnt_ff <= 2'd0;
         hex_acc_ff <= 4'd0;
         failed_ff  <= 1'b0;
      end else if (advance) begin
         phase_ff   <= phase_in;
         hex_cnt_ff <= hex_cnt_in;
         hex_acc_ff <= hex_acc_in;
         failed_ff  <= failed_in;
      end
   end

endmodule

`default_nettype wire

>>> design/qsu_rsp_reg.sv
// Result register of the unescaper: holds one response word until taken.
// Depends on qsu_pkg.
`default_nettype none

module qsu_rsp_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  qsu_pkg::rsp_type result,
   output logic             space,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output qsu_pkg::rsp_type rsp_data
);
   import qsu_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign space     = !valid_ff || rsp_ready;
   assign valid_in  = load || (valid_ff && !rsp_ready);
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

endmodule

`default_nettype wire

>>> design/qsu_checker.sv
// Port-level checks of the quoted string unescaper and their binding.
// Depends on qsu_pkg and quoted_string_unescape_macros.svh.
`default_nettype none

`include "quoted_string_unescape_macros.svh"

module qsu_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input qsu_pkg::rsp_type rsp_data
);
   import qsu_pkg::*;

   logic ok_word;
   logic empty_word;
   logic stalled;

   assign ok_word    = rsp_valid && rsp_data.text_ok;
   assign empty_word = rsp_valid && !rsp_data.char_valid;
   assign stalled    = rsp_valid && !rsp_ready;

   // Success is only reported on the word that ends a text.
   `QSU_ASSERT_IMPLY(ok_only_at_end, clock, reset, ok_word, rsp_data.text_end)

   // A word that carries no decoded byte shows a zero byte.
   `QSU_ASSERT_IMPLY(char_zero_when_empty, clock, reset, empty_word, rsp_data.out_char == 8'h00)

   // The closing quote of a good text never carries a decoded byte.
   `QSU_ASSERT_IMPLY(no_char_on_success, clock, reset, ok_word, !rsp_data.char_valid)

   // A stalled response word stays put.
   `QSU_ASSERT_NEXT(rsp_hold, clock, reset, stalled, rsp_valid && $stable(rsp_data))

endmodule

bind quoted_string_unescape qsu_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

>>> test/unescape_scoreboard_pkg.sv
// Scoreboard for the quoted string unescaper testbench: a bytewise decoder model
// and an in-order store of the response words it predicts. Depends on qsu_pkg.
package unescape_scoreboard_pkg;

   import qsu_pkg::*;

   class unescape_scoreboard;

      // Parser state mirrored from the block.
      phase_type  phase;
      logic [1:0] hex_seen;
      logic [7:0] hex_acc;
      bit         failed;

      rsp_type    decoded_words[$];
      int         errors;
      int         texts_total;
      int         texts_good;
      int         chars_out;
      int         bytes_in;

      function new();
         restart();
         errors      = 0;
         texts_total = 0;
         texts_good  = 0;
         chars_out   = 0;
         bytes_in    = 0;
      endfunction

      function void restart();
         phase    = PH_OPEN;
         hex_seen = 2'd0;
         hex_acc  = 8'h00;
         failed   = 1'b0;
      endfunction

      // Digit value, or -1 when the byte is no hex digit.
      function int hex_value(logic [7:0] c);
         if (c >= CHAR_ZERO && c <= CHAR_NINE) return int'(c - CHAR_ZERO);
         if (c >= CHAR_LOW_A && c <= CHAR_LOW_F) return int'(c - CHAR_LOW_A) + 10;
         if (c >= CHAR_UP_A && c <= CHAR_UP_F) return int'(c - CHAR_UP_A) + 10;
         return -1;
      endfunction

      // Advances the parser by one raw byte and returns the word it causes.
      function rsp_type unescape_byte(req_type w);
         rsp_type    r;
         logic [7:0] c;
         bit         fin;
         bit         ok;
         int         d;
         r   = '0;
         c   = w.in_byte;
         fin = w.is_final;
         ok  = 1'b0;
         if (!failed) begin
            case (phase)
               PH_OPEN: begin
                  if (c != CHAR_QUOTE || fin) failed = 1'b1;
                  else phase = PH_BODY;
               end
               PH_BODY: begin
                  if (fin) begin
                     if (c == CHAR_QUOTE) ok = 1'b1;
                     else failed = 1'b1;
                  end else if (c == CHAR_QUOTE || c < CTRL_LIMIT) begin
                     failed = 1'b1;
                  end else if (c == CHAR_BSLASH) begin
                     phase = PH_ESC;
                  end else begin
                     r.char_valid = 1'b1;
                     r.out_char   = c;
                  end
               end
               PH_ESC: begin
                  if (fin) begin
                     failed = 1'b1;
                  end else begin
                     phase        = PH_BODY;
                     r.char_valid = 1'b1;
                     case (c)
                        CHAR_QUOTE, CHAR_BSLASH: r.out_char = c;
                        CHAR_LOW_B:              r.out_char = CODE_BS;
                        CHAR_LOW_F:              r.out_char = CODE_FF;
                        CHAR_LOW_N:              r.out_char = CODE_LF;
                        CHAR_LOW_R:              r.out_char = CODE_CR;
                        CHAR_LOW_T:              r.out_char = CODE_TAB;
                        CHAR_LOW_U: begin
                           r.char_valid = 1'b0;
                           phase        = PH_HEX;
                           hex_seen     = 2'd0;
                           hex_acc      = 8'h00;
                        end
                        default: begin
                           r.char_valid = 1'b0;
                           failed       = 1'b1;
                        end
                     endcase
                  end
               end
               default: begin
                  d = hex_value(c);
                  if (fin || d < 0) begin
                     failed = 1'b1;
                  end else if (hex_seen < HEX_ZEROS) begin
                     // The two leading digits must be zero to stay within a byte.
                     if (d != 0) failed = 1'b1;
                     else hex_seen = hex_seen + 2'd1;
                  end else if (hex_seen == HEX_ZEROS) begin
                     hex_acc  = 8'(d);
                     hex_seen = HEX_LAST;
                  end else begin
                     r.char_valid = 1'b1;
                     r.out_char   = {hex_acc[3:0], 4'(d)};
                     phase        = PH_BODY;
                     hex_seen     = 2'd0;
                     hex_acc      = 8'h00;
                  end
               end
            endcase
         end
         r.text_end = fin;
         r.text_ok  = fin && ok && !failed;
         if (fin) restart();
         return r;
      endfunction

      function void take_byte(req_type w);
         rsp_type r;
         r = unescape_byte(w);
         bytes_in++;
         if (r.char_valid) chars_out++;
         if (r.text_end) texts_total++;
         if (r.text_ok) texts_good++;
         decoded_words.insert(decoded_words.size(), r);
      endfunction

      function void match_word(rsp_type got);
         rsp_type want;
         if (decoded_words.size() == 0) begin
            $error("response word %h arrived with nothing outstanding", got);
            errors++;
            return;
         end
         want = decoded_words.pop_front();
         if (got.char_valid !== want.char_valid) begin
            $error("char_valid: expected %0b, got %0b", want.char_valid, got.char_valid);
            errors++;
         end
         if (got.out_char !== want.out_char) begin
            $error("out_char: expected %02h, got %02h", want.out_char, got.out_char);
            errors++;
         end
         if (got.text_end !== want.text_end) begin
            $error("text_end: expected %0b, got %0b", want.text_end, got.text_end);
            errors++;
         end
         if (got.text_ok !== want.text_ok) begin
            $error("text_ok: expected %0b, got %0b", want.text_ok, got.text_ok);
            errors++;
         end
      endfunction

      function int outstanding();
         return decoded_words.size();
      endfunction

      function void flag_leftovers();
         if (decoded_words.size() != 0) begin
            $error("%0d response words never arrived", decoded_words.size());
            errors++;
         end
      endfunction

   endclass

endpackage

>>> test/tb_quoted_string_unescape.sv
// Testbench of the quoted string unescaper: directed texts, then random texts
// with random idling on both channels. Depends on qsu_pkg and unescape_scoreboard_pkg.
module tb_quoted_string_unescape;

   timeunit 1ns;
   timeprecision 1ps;

   import qsu_pkg::*;
   import unescape_scoreboard_pkg::*;

   typedef logic [7:0] octets [$];

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // While steady is set, neither side idles, so the block runs at full rate.
   bit      steady     = 1'b0;
   int      words_sent = 0;

   unescape_scoreboard sb = new();

   quoted_string_unescape dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // Both channels are observed at the rising edge. An accepted request word is
   // fed to the model first, so the store is current before any response check.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.take_byte(req_data);
         if (rsp_valid && rsp_ready) sb.match_word(rsp_data);
      end
   end

   // The response side stalls about 35 times in a hundred, except while the
   // steady stretch runs. Ready changes only at the falling edge.
   initial begin
      forever begin
         @(negedge clock);
         rsp_ready <= !reset && (steady || $urandom_range(0, 99) >= 35);
      end
   end

   // Presents one word at a falling edge, after a random number of idle cycles,
   // and holds it until the block takes it at a rising edge.
   task automatic send_word(input req_type w);
      @(negedge clock);
      while (!steady && $urandom_range(0, 99) < 35) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do begin
         @(posedge clock);
      end while (!req_ready);
      words_sent++;
   endtask

   // Sends a whole text; the last byte carries the final flag.
   task automatic send_text(input octets t);
      req_type w;
      foreach (t[i]) begin
         w.in_byte  = t[i];
         w.is_final = (i == t.size() - 1);
         send_word(w);
      end
   endtask

   // Appends one byte at the end of a text.
   function automatic void append_byte(ref octets t, input logic [7:0] c);
      t.insert(t.size(), c);
   endfunction

   // A hex digit character of the given value, in random letter case.
   function automatic logic [7:0] hex_char(input int v);
      if (v < 10) return CHAR_ZERO + 8'(v);
      return ($urandom_range(0, 1) ? CHAR_LOW_A : CHAR_UP_A) + 8'(v - 10);
   endfunction

   function automatic logic [7:0] escape_letter(input int k);
      case (k)
         0:       return CHAR_QUOTE;
         1:       return CHAR_BSLASH;
         2:       return CHAR_LOW_B;
         3:       return CHAR_LOW_F;
         4:       return CHAR_LOW_N;
         5:       return CHAR_LOW_R;
         default: return CHAR_LOW_T;
      endcase
   endfunction

   // A printable body byte that needs no escape; the upper half passes as is.
   function automatic logic [7:0] plain_byte();
      logic [7:0] c;
      do begin
         c = 8'($urandom_range(32, 255));
      end while (c == CHAR_QUOTE || c == CHAR_BSLASH);
      return c;
   endfunction

   // Builds a well-formed quoted text with random content: plain bytes, short
   // escapes and four-digit hex escapes whose value fits in a byte.
   function automatic void make_clean_text(ref octets t);
      int n;
      int k;
      t = '{CHAR_QUOTE};
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
      repeat (n) begin
         k = $urandom_range(0, 9);
         if (k < 5) begin
            append_byte(t, plain_byte());
         end else if (k < 8) begin
            append_byte(t, CHAR_BSLASH);
            append_byte(t, escape_letter($urandom_range(0, 6)));
         end else begin
            append_byte(t, CHAR_BSLASH);
            append_byte(t, CHAR_LOW_U);
            append_byte(t, CHAR_ZERO);
            append_byte(t, CHAR_ZERO);
            append_byte(t, hex_char($urandom_range(0, 15)));
            append_byte(t, hex_char($urandom_range(0, 15)));
         end
      end
      append_byte(t, CHAR_QUOTE);
   endfunction

   // Breaks a clean text in one of several ways, or replaces it by noise.
   function automatic void spoil_text(ref octets t);
      int pos;
      pos = $urandom_range(1, t.size() - 1);
      case ($urandom_range(0, 5))
         0: t[$urandom_range(0, t.size() - 1)] = 8'($urandom_range(0, 255));
         1: begin
            // Cut the text short so an escape or hex run may hit the final byte.
            while (t.size() > pos) void'(t.pop_back());
         end
         2: begin
            t = {};
            repeat ($urandom_range(1, 6)) append_byte(t, 8'($urandom_range(0, 255)));
         end
         3: t.insert(pos, 8'($urandom_range(0, 31)));
         4: begin
            // A hex escape with random digits, usually too large or malformed.
            t.insert(pos, CHAR_BSLASH);
            t.insert(pos + 1, CHAR_LOW_U);
            repeat (4) t.insert(pos + 2, ($urandom_range(0, 3) == 0)
                                         ? 8'($urandom_range(0, 255))
                                         : hex_char($urandom_range(0, 15)));
         end
         default: begin
            t.insert(pos, CHAR_BSLASH);
            t.insert(pos + 1, 8'($urandom_range(0, 255)));
         end
      endcase
   endfunction

   initial begin
      octets t;

      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // Every short escape, a byte above 0xFF's lower half through a hex escape,
      // and a clean closing quote.
      send_text('{CHAR_QUOTE, CHAR_BSLASH, CHAR_LOW_B, CHAR_BSLASH, CHAR_LOW_F,
                  CHAR_BSLASH, CHAR_LOW_N, CHAR_BSLASH, CHAR_LOW_R, CHAR_BSLASH,
                  CHAR_LOW_T, CHAR_BSLASH, CHAR_QUOTE, CHAR_BSLASH, CHAR_BSLASH,
                  CHAR_BSLASH, CHAR_LOW_U, CHAR_ZERO, CHAR_ZERO, CHAR_UP_A,
                  CHAR_LOW_F, CHAR_QUOTE});
      // A text of one byte fails even when that byte is a quote.
      send_text('{CHAR_QUOTE});
      // A missing opening quote, with the all-zero byte in front.
      send_text('{8'h00, CHAR_QUOTE});
      // The all-ones byte passes through, the control byte just below 0x20 fails.
      send_text('{CHAR_QUOTE, 8'hff, 8'h1f, CHAR_QUOTE});
      // A bare quote inside the body.
      send_text('{CHAR_QUOTE, CHAR_QUOTE, CHAR_QUOTE});
      // An unknown escape letter.
      send_text('{CHAR_QUOTE, CHAR_BSLASH, 8'h71, CHAR_QUOTE});
      // An escape cut off by the final quote.
      send_text('{CHAR_QUOTE, CHAR_BSLASH, CHAR_QUOTE});
      // A nonzero leading hex digit, which would give a value above 0xFF.
      send_text('{CHAR_QUOTE, CHAR_BSLASH, CHAR_LOW_U, 8'h31, CHAR_QUOTE});
      // A hex run cut off by the final quote.
      send_text('{CHAR_QUOTE, CHAR_BSLASH, CHAR_LOW_U, CHAR_ZERO, CHAR_ZERO,
                  CHAR_QUOTE});

      // Random texts: most are well formed, about 30 in a hundred are broken.
      while (words_sent < 1650) begin
         steady = (words_sent >= 700 && words_sent < 1000);
         make_clean_text(t);
         if ($urandom_range(0, 99) < 30) spoil_text(t);
         send_text(t);
      end
      steady = 1'b0;

      @(negedge clock);
      req_valid <= 1'b0;

      while (sb.outstanding() != 0) @(posedge clock);
      // Waiting on after the store empties catches any extra word.
      repeat (8) @(posedge clock);
      sb.flag_leftovers();

      $display("Sent %0d raw bytes in %0d texts; %0d texts decoded cleanly, %0d bytes out.",
               sb.bytes_in, sb.texts_total, sb.texts_good, sb.chars_out);
      if (sb.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Far beyond the slowest correct run of about 1700 words with random stalls.
   initial begin
      #2_000_000;
      $display("Timeout with %0d response words outstanding.", sb.outstanding());
      $display("Test completed with failures");
      $finish;
   end

endmodule

>>> files.f
+incdir+design
design/qsu_pkg.sv
design/qsu_in_reg.sv
design/qsu_decode.sv
design/qsu_rsp_reg.sv
design/quoted_string_unescape.sv
design/qsu_checker.sv
test/unescape_scoreboard_pkg.sv
test/tb_quoted_string_unescape.sv
